### rtl/midpoint_line_pixel_generator_assert.svh
// Assertion macros shared by the checker of the line pixel generator.
// No dependencies; include this file by its bare name.
`ifndef MIDPOINT_LINE_PIXEL_GENERATOR_ASSERT_SVH
`define MIDPOINT_LINE_PIXEL_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLPG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MLPG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check that is also active while reset is asserted.
`define MLPG_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/mlpg_pkg.sv
// Shared constants for the midpoint line pixel generator.
// No dependencies.
`default_nettype none

package mlpg_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

`default_nettype wire

### rtl/mlpg_core.sv
// Line state registers and the combinational load and step arithmetic.
// Depends on mlpg_pkg for the operation codes.
`default_nettype none

module mlpg_core #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_accept,
    input  wire logic                    in_op,
    input  wire logic [COORD_BITS-1:0]   in_x_start,
    input  wire logic [COORD_BITS-1:0]   in_y_start,
    input  wire logic [COORD_BITS-1:0]   in_x_end,
    input  wire logic [COORD_BITS-1:0]   in_y_end,
    output logic                         res_push,
    output logic [2*COORD_BITS:0]        res_data
);

    localparam int DEC_W = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;
    logic [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0] major_len_reg, major_len_next;
    logic [COORD_BITS-1:0] minor_len_reg, minor_len_next;
    logic                  x_dir_neg_reg, x_dir_neg_next;
    logic                  y_dir_neg_reg, y_dir_neg_next;
    logic                  y_is_major_reg, y_is_major_next;
    logic                  active_reg, active_next;

    logic                  ld_x_neg, ld_y_neg, ld_y_major;
    logic [COORD_BITS-1:0] ld_adx, ld_ady, ld_major, ld_minor;
    logic                  minor_step;
    logic [COORD_BITS-1:0] x_moved, y_moved;
    logic [DEC_W-1:0]      minor2, major2;
    logic                  last;

    always_comb begin
        ld_x_neg   = in_x_end < in_x_start;
        ld_y_neg   = in_y_end < in_y_start;
        ld_adx     = ld_x_neg ? (in_x_start - in_x_end) : (in_x_end - in_x_start);
        ld_ady     = ld_y_neg ? (in_y_start - in_y_end) : (in_y_end - in_y_start);
        ld_y_major = ld_ady > ld_adx;
        ld_major   = ld_y_major ? ld_ady : ld_adx;
        ld_minor   = ld_y_major ? ld_adx : ld_ady;

        minor_step = !decision_reg[DEC_W-1];
        x_moved    = x_dir_neg_reg ? (cur_x_reg - ONE) : (cur_x_reg + ONE);
        y_moved    = y_dir_neg_reg ? (cur_y_reg - ONE) : (cur_y_reg + ONE);
        minor2     = {2'b00, minor_len_reg, 1'b0};
        major2     = {2'b00, major_len_reg, 1'b0};
    end

    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        decision_next   = decision_reg;
        steps_left_next = steps_left_reg;
        major_len_next  = major_len_reg;
        minor_len_next  = minor_len_reg;
        x_dir_neg_next  = x_dir_neg_reg;
        y_dir_neg_next  = y_dir_neg_reg;
        y_is_major_next = y_is_major_reg;
        active_next     = active_reg;
        res_push        = 1'b0;
        last            = 1'b0;

        if (in_accept) begin
            if (in_op == mlpg_pkg::OP_LOAD) begin
                x_dir_neg_next  = ld_x_neg;
                y_dir_neg_next  = ld_y_neg;
                y_is_major_next = ld_y_major;
                major_len_next  = ld_major;
                minor_len_next  = ld_minor;
                decision_next   = {2'b00, ld_minor, 1'b0} - {3'b000, ld_major};
                steps_left_next = ld_major;
                cur_x_next      = in_x_start;
                cur_y_next      = in_y_start;
                active_next     = ld_major != '0;
                last            = ld_major == '0;
                res_push        = 1'b1;
            end else if (active_reg) begin
                if (y_is_major_reg) begin
                    cur_y_next = y_moved;
                    if (minor_step) begin
                        cur_x_next = x_moved;
                    end
                end else begin
                    cur_x_next = x_moved;
                    if (minor_step) begin
                        cur_y_next = y_moved;
                    end
                end
                if (minor_step) begin
                    decision_next = decision_reg + minor2 - major2;
                end else begin
                    decision_next = decision_reg + minor2;
                end
                steps_left_next = steps_left_reg - ONE;
                last            = steps_left_reg == ONE;
                active_next     = !last;
                res_push        = 1'b1;
            end
        end
    end

    assign res_data = {last, cur_y_next, cur_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            decision_reg   <= '0;
            steps_left_reg <= '0;
            major_len_reg  <= '0;
            minor_len_reg  <= '0;
            x_dir_neg_reg  <= 1'b0;
            y_dir_neg_reg  <= 1'b0;
            y_is_major_reg <= 1'b0;
            active_reg     <= 1'b0;
        end else begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            decision_reg   <= decision_next;
            steps_left_reg <= steps_left_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            x_dir_neg_reg  <= x_dir_neg_next;
            y_dir_neg_reg  <= y_dir_neg_next;
            y_is_major_reg <= y_is_major_next;
            active_reg     <= active_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mlpg_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
// No dependencies.
`default_nettype none

module mlpg_out_buf #(
    parameter int DATA_W = 21
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   can_push,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] main_data_reg, main_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

### rtl/midpoint_line_pixel_generator.sv
// Each pixel is registered in the output register, or in the skid register on a stall.
// Throughput: one input transfer per cycle while the skid register is empty; the line
// step is one add and compare on the state registers, and the skid register keeps input
// open for one stalled result. Reset (aresetn low, synchronous) drops any line in
// progress and empties the result buffer. Depends on mlpg_pkg, mlpg_core and mlpg_out_buf.
`default_nettype none

module midpoint_line_pixel_generator #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded to bytes.
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // op: 0 loads endpoints, 1 steps to the next pixel.
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pixel_x, pixel_y from bit 0 up, zero padded to bytes.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,
    output logic                                     m_tlast
);

    localparam int OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int RES_W       = 2*COORD_BITS + 1;

    logic              in_accept;
    logic              res_push;
    logic [RES_W-1:0]  res_data;
    logic [RES_W-1:0]  out_data;

    assign in_accept = s_tvalid && s_tready;

    mlpg_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_op     (s_tuser),
        .in_x_start(s_tdata[COORD_BITS-1:0]),
        .in_y_start(s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_x_end  (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_y_end  (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    mlpg_out_buf #(
        .DATA_W(RES_W)
    ) u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .push_data(res_data),
        .can_push (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    assign m_tdata = OUT_TDATA_W'(out_data[2*COORD_BITS-1:0]);
    assign m_tlast = out_data[2*COORD_BITS];

endmodule

`default_nettype wire

### rtl/mlpg_checker.sv
// Port-level checks of the line pixel generator, bound to its top level.
// Depends on mlpg_pkg and midpoint_line_pixel_generator_assert.svh.
`default_nettype none

`include "midpoint_line_pixel_generator_assert.svh"

module mlpg_checker #(
    parameter int COORD_BITS = 10
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    // op: 0 loads endpoints, 1 steps to the next pixel.
    input wire logic                                s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    // pixel_x, pixel_y from bit 0 up, zero padded to bytes.
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    input wire logic                                m_tlast
);

    `MLPG_ASSERT_RESET(a_reset_empties, aclk, !aresetn, !m_tvalid)
    `MLPG_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `MLPG_ASSERT_NOW(a_backpressure_only_when_full, aclk, aresetn, !s_tready, m_tvalid)
    `MLPG_ASSERT_NEXT(a_load_gives_pixel, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == mlpg_pkg::OP_LOAD) && !m_tvalid, m_tvalid)

endmodule

bind midpoint_line_pixel_generator mlpg_checker #(
    .COORD_BITS(COORD_BITS)
) u_mlpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire

### tb/tb_midpoint_line_pixel_generator.sv
// Testbench for midpoint_line_pixel_generator: drives load and step transfers with random
// gaps and result stalls, and checks every pixel against a built-in line tracer.
// Depends on mlpg_pkg and the midpoint_line_pixel_generator RTL.
`timescale 1ns / 100ps

module tb_midpoint_line_pixel_generator;

    localparam int CB = 10;
    localparam int S_W = ((4 * CB + 7) / 8) * 8;
    localparam int M_W = ((2 * CB + 7) / 8) * 8;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int N_ITEMS = 1350;
    localparam int CALM_TAIL = 120;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic          op;
        logic [CB-1:0] x0;
        logic [CB-1:0] y0;
        logic [CB-1:0] x1;
        logic [CB-1:0] y1;
        logic          drain;
    } line_cmd_t;

    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          last;
    } pixel_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // x_start, y_start, x_end, y_end from bit 0 up.
    logic [S_W-1:0] s_tdata = '0;
    // op.
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // pixel_x, pixel_y from bit 0 up.
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    line_cmd_t cmd_q[$];
    pixel_t    pixel_q[$];
    line_cmd_t on_bus;
    int        n_cmds = 0;
    int        n_sent = 0;
    int        n_pix = 0;
    int        errors = 0;
    int        gap_left = 0;
    int        stall_left = 0;

    logic [CB-1:0]        ln_x = '0;
    logic [CB-1:0]        ln_y = '0;
    logic signed [CB+2:0] ln_err = '0;
    logic [CB-1:0]        ln_left = '0;
    logic [CB-1:0]        ln_major = '0;
    logic [CB-1:0]        ln_minor = '0;
    logic                 ln_xneg = 1'b0;
    logic                 ln_yneg = 1'b0;
    logic                 ln_ymajor = 1'b0;
    logic                 ln_active = 1'b0;

    midpoint_line_pixel_generator #(.COORD_BITS(CB)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void trace_pixel(input line_cmd_t c);
        int     adx;
        int     ady;
        logic   minor_step;
        pixel_t p;
        if (c.op == mlpg_pkg::OP_LOAD) begin
            ln_xneg = c.x1 < c.x0;
            ln_yneg = c.y1 < c.y0;
            adx = ln_xneg ? int'(c.x0) - int'(c.x1) : int'(c.x1) - int'(c.x0);
            ady = ln_yneg ? int'(c.y0) - int'(c.y1) : int'(c.y1) - int'(c.y0);
            ln_ymajor = ady > adx;
            ln_major = ln_ymajor ? CB'(ady) : CB'(adx);
            ln_minor = ln_ymajor ? CB'(adx) : CB'(ady);
            ln_err = (CB + 3)'(2 * int'(ln_minor) - int'(ln_major));
            ln_left = ln_major;
            ln_x = c.x0;
            ln_y = c.y0;
            ln_active = ln_major != 0;
        end else begin
            if (!ln_active) return;
            minor_step = ln_err >= 0;
            if (ln_ymajor) begin
                ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
                if (minor_step) ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
            end else begin
                ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
                if (minor_step) ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
            end
            if (minor_step) begin
                ln_err = (CB + 3)'(int'(ln_err) + 2 * (int'(ln_minor) - int'(ln_major)));
            end else begin
                ln_err = (CB + 3)'(int'(ln_err) + 2 * int'(ln_minor));
            end
            ln_left = ln_left - 1'b1;
            if (ln_left == 0) ln_active = 1'b0;
        end
        p.px = ln_x;
        p.py = ln_y;
        p.last = !ln_active;
        pixel_q.push_back(p);
    endfunction

    function automatic void add_cmd(input logic op, input int x0, input int y0,
                                    input int x1, input int y1, input logic drain);
        line_cmd_t c;
        c.op = op;
        c.x0 = CB'(x0);
        c.y0 = CB'(y0);
        c.x1 = CB'(x1);
        c.y1 = CB'(y1);
        c.drain = drain;
        cmd_q.push_back(c);
        n_cmds++;
    endfunction

    function automatic void add_step();
        add_cmd(mlpg_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom, 1'b0);
    endfunction

    function automatic int near_coord(input int c, input int span);
        int v;
        v = c + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    function automatic int major_of(input int x0, input int y0, input int x1, input int y1);
        int adx;
        int ady;
        adx = x1 > x0 ? x1 - x0 : x0 - x1;
        ady = y1 > y0 ? y1 - y0 : y0 - y1;
        return adx >= ady ? adx : ady;
    endfunction

    // Driver: presents queued commands, traces each accepted transfer.
    always @(posedge aclk) begin
        logic      present;
        logic      calm;
        line_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                trace_pixel(on_bus);
                n_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                present = 1'b0;
                calm = cmd_q.size() < CALM_TAIL;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!calm && ((n_sent / 128) % 4) != 3 && $urandom_range(15) == 0) begin
                    gap_left = $urandom_range(14);
                end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && pixel_q.size() != 0)) begin
                    nxt = cmd_q.pop_front();
                    on_bus = nxt;
                    s_tdata <= {nxt.y1, nxt.x1, nxt.y0, nxt.x0};
                    s_tuser <= nxt.op;
                    present = 1'b1;
                end
                s_tvalid <= present;
            end
        end
    end

    // Monitor: random result stalls and pixel checks.
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_pix++;
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d last=%0b",
                           m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[CB-1:0] !== want.px) begin
                        $error("pixel_x: expected %0d, got %0d", want.px, m_tdata[CB-1:0]);
                        errors++;
                    end
                    if (m_tdata[2*CB-1:CB] !== want.py) begin
                        $error("pixel_y: expected %0d, got %0d", want.py, m_tdata[2*CB-1:CB]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_pixel: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (cmd_q.size() >= CALM_TAIL && ((n_pix / 128) % 4) != 3
                         && $urandom_range(11) == 0) begin
                stall_left = $urandom_range(14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("midpoint_line_pixel_generator: mismatch");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int n_steps;

        add_step();
        add_cmd(mlpg_pkg::OP_LOAD, 0, 0, 0, 0, 1'b0);
        add_cmd(mlpg_pkg::OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        add_cmd(mlpg_pkg::OP_LOAD, 0, 0, COORD_MAX, COORD_MAX, 1'b0);
        repeat (2) add_step();
        add_cmd(mlpg_pkg::OP_LOAD, COORD_MAX, 0, COORD_MAX - 3, 1, 1'b0);
        repeat (4) add_step();
        add_cmd(mlpg_pkg::OP_LOAD, 5, 5, 3, 10, 1'b0);
        repeat (5) add_step();
        add_cmd(mlpg_pkg::OP_LOAD, 7, 9, 7, 6, 1'b0);
        repeat (3) add_step();
        add_cmd(mlpg_pkg::OP_LOAD, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        repeat (2) add_step();

        while (n_cmds < N_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 85) begin
                span = kind < 3 ? 400 : ($urandom_range(3) == 0 ? 40 : 8);
                x0 = $urandom_range(COORD_MAX);
                y0 = $urandom_range(COORD_MAX);
                x1 = near_coord(x0, span);
                y1 = near_coord(y0, span);
                n_steps = major_of(x0, y0, x1, y1);
                if ($urandom_range(9) == 0) n_steps = $urandom_range(n_steps);
                else if ($urandom_range(9) == 0) n_steps += $urandom_range(1, 3);
                add_cmd(mlpg_pkg::OP_LOAD, x0, y0, x1, y1,
                        n_cmds < 60 || $urandom_range(39) == 0);
                repeat (n_steps) begin
                    if (n_cmds < N_ITEMS) add_step();
                end
            end else begin
                add_cmd($urandom_range(1), $urandom, $urandom, $urandom, $urandom, 1'b0);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (cmd_q.size() != 0 || s_tvalid || pixel_q.size() != 0);
        repeat (4) @(negedge aclk);

        if (pixel_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pixel_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("midpoint_line_pixel_generator: match");
        end else begin
            $display("midpoint_line_pixel_generator: mismatch");
        end
        $finish;
    end
endmodule
